// ----- rtl/core/y86isc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package y86isc_pkg;

   localparam int MEM_BYTES_DEFAULT = 8192;
   localparam int REG_COUNT = 15;

   localparam logic [3:0] RSP_ID = 4'd4;
   localparam logic [3:0] NO_REG = 4'd15;

   localparam logic [1:0] ACT_LOAD     = 2'd0;
   localparam logic [1:0] ACT_EXEC     = 2'd1;
   localparam logic [1:0] ACT_READ_MEM = 2'd2;
   localparam logic [1:0] ACT_READ_REG = 2'd3;

   localparam logic [1:0] ST_AOK = 2'd0;
   localparam logic [1:0] ST_HLT = 2'd1;
   localparam logic [1:0] ST_ADR = 2'd2;
   localparam logic [1:0] ST_INS = 2'd3;

   localparam logic [3:0] IC_HALT  = 4'h0;
   localparam logic [3:0] IC_NOP   = 4'h1;
   localparam logic [3:0] IC_CMOV  = 4'h2;
   localparam logic [3:0] IC_IRMOV = 4'h3;
   localparam logic [3:0] IC_RMMOV = 4'h4;
   localparam logic [3:0] IC_MRMOV = 4'h5;
   localparam logic [3:0] IC_OP    = 4'h6;
   localparam logic [3:0] IC_JXX   = 4'h7;
   localparam logic [3:0] IC_CALL  = 4'h8;
   localparam logic [3:0] IC_RET   = 4'h9;
   localparam logic [3:0] IC_PUSH  = 4'hA;
   localparam logic [3:0] IC_POP   = 4'hB;

   localparam logic [3:0] ALU_ADD = 4'd0;
   localparam logic [3:0] ALU_SUB = 4'd1;
   localparam logic [3:0] ALU_AND = 4'd2;
   localparam logic [3:0] ALU_XOR = 4'd3;

   localparam logic [3:0] COND_ALWAYS = 4'd0;
   localparam logic [3:0] COND_LE     = 4'd1;
   localparam logic [3:0] COND_L      = 4'd2;
   localparam logic [3:0] COND_E      = 4'd3;
   localparam logic [3:0] COND_NE     = 4'd4;
   localparam logic [3:0] COND_GE     = 4'd5;
   localparam logic [3:0] COND_G      = 4'd6;

   localparam logic [2:0] FLAGS_RESET = 3'b100;

   typedef struct packed {
      logic [1:0]  action;
      logic [12:0] address;
      logic [7:0]  load_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] program_counter;
      logic [2:0]  flags;
      logic [63:0] read_value;
   } rsp_type;

   typedef struct packed {
      logic        en;
      logic [3:0]  id;
      logic [63:0] value;
   } rf_wr_type;

   function automatic logic cond_met(input logic [3:0] fn, input logic [2:0] cc);
      logic z;
      logic lt;
      logic r;
      z  = cc[2];
      lt = cc[1] ^ cc[0];
      case (fn)
         COND_ALWAYS: r = 1'b1;
         COND_LE:     r = z | lt;
         COND_L:      r = lt;
         COND_E:      r = z;
         COND_NE:     r = ~z;
         COND_GE:     r = ~lt;
         COND_G:      r = ~lt & ~z;
         default:     r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic need_reg(input logic [3:0] ic);
      logic r;
      case (ic) inside
         IC_CMOV, IC_IRMOV, IC_RMMOV, IC_MRMOV, IC_OP, IC_PUSH, IC_POP: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic need_imm(input logic [3:0] ic);
      logic r;
      case (ic) inside
         IC_IRMOV, IC_RMMOV, IC_MRMOV, IC_JXX, IC_CALL: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/y86isc_regfile.sv -----
`timescale 1ns / 1ps
`default_nettype none

module y86isc_regfile (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire y86isc_pkg::rf_wr_type wr,
   input  wire logic [3:0]            rd_id,
   output logic [63:0]                rd_value
);

   logic [63:0] rf [y86isc_pkg::REG_COUNT];
   logic [y86isc_pkg::REG_COUNT-1:0] vld_ff;
   logic [63:0] rd_ff;
   logic        rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr.en && wr.id != y86isc_pkg::NO_REG) begin
            vld_ff[wr.id] <= 1'b1;
         end
         rd_vld_ff <= (rd_id != y86isc_pkg::NO_REG) && vld_ff[rd_id];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.id != y86isc_pkg::NO_REG) begin
         rf[wr.id] <= wr.value;
      end
      if (rd_id != y86isc_pkg::NO_REG) begin
         rd_ff <= rf[rd_id];
      end
   end

   assign rd_value = rd_vld_ff ? rd_ff : 64'd0;

endmodule

`default_nettype wire

// ----- rtl/core/y86_instruction_step_core_top.sv -----
// from accept to rsp_valid: a load goes straight to the result state, a byte or register read
// passes one wait state first; execute goes byte by byte through the one memory read port: up to ten fetch bytes,
// three register file reads in turn, then up to eight data bytes read or written
// throughput: one transaction in flight; the next is taken once the result is registered
// reset: synchronous, clears pc and register valid bits, sets flags to FLAGS_RESET, then sweeps
// every memory byte to zero with req_stall high
`timescale 1ns / 1ps
`default_nettype none

module y86_instruction_step_core_top #(
   parameter int MEM_BYTES = y86isc_pkg::MEM_BYTES_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire y86isc_pkg::req_type req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output y86isc_pkg::rsp_type      rsp_data
);

   localparam int AW = $clog2(MEM_BYTES);
   localparam logic [63:0] MEM_LIMIT = 64'(MEM_BYTES);
   localparam logic [63:0] SPAN8_MAX = 64'(MEM_BYTES - 8);
   localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_MRDW  = 4'd2;
   localparam logic [3:0] S_RRDW  = 4'd3;
   localparam logic [3:0] S_F0    = 4'd4;
   localparam logic [3:0] S_F0W   = 4'd5;
   localparam logic [3:0] S_F1W   = 4'd6;
   localparam logic [3:0] S_IMM   = 4'd7;
   localparam logic [3:0] S_DEC   = 4'd8;
   localparam logic [3:0] S_REGRD = 4'd9;
   localparam logic [3:0] S_EXEC  = 4'd10;
   localparam logic [3:0] S_DRD   = 4'd11;
   localparam logic [3:0] S_DWR   = 4'd12;
   localparam logic [3:0] S_RWR1  = 4'd13;
   localparam logic [3:0] S_RWR2  = 4'd14;
   localparam logic [3:0] S_RESP  = 4'd15;

   logic [7:0] mem [MEM_BYTES];
   logic [7:0] mem_rd_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [7:0]    mem_wd;

   y86isc_pkg::rf_wr_type rf_wr;
   logic [3:0]  rf_ra;
   logic [63:0] rf_rdata;

   logic [3:0]  state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [63:0] pc_ff, pc_in;
   logic [63:0] p_ff, p_in;
   logic [63:0] np_ff, np_in;
   logic [2:0]  flags_ff, flags_in;
   logic [3:0]  icode_ff, icode_in, ifun_ff, ifun_in;
   logic [3:0]  ra_ff, ra_in, rb_ff, rb_in;
   logic [63:0] imm_ff, imm_in;
   logic [63:0] va_ff, va_in, vb_ff, vb_in, vsp_ff, vsp_in;
   logic [63:0] addr_ff, addr_in;
   logic [63:0] data_ff, data_in;
   logic [1:0]  status_ff, status_in;
   logic [63:0] rv_ff, rv_in;
   y86isc_pkg::rf_wr_type wr1_ff, wr1_in, wr2_ff, wr2_in;
   logic        rsp_valid_ff, rsp_valid_in;
   y86isc_pkg::rsp_type rsp_ff, rsp_in;

   logic        req_acc;
   logic [63:0] rd8_val;
   logic [63:0] ea;
   logic [63:0] alu_v;
   logic        alu_o;
   logic        cond;
   logic        bad_fn;

   y86isc_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .wr       (rf_wr),
      .rd_id    (rf_ra),
      .rd_value (rf_rdata)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_ra];
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rd8_val   = {mem_rd_ff, data_ff[63:8]};
   assign cond      = y86isc_pkg::cond_met(ifun_ff, flags_ff);
   assign bad_fn    = ((icode_ff == y86isc_pkg::IC_CMOV || icode_ff == y86isc_pkg::IC_JXX)
                       && ifun_ff > y86isc_pkg::COND_G)
                   || (icode_ff == y86isc_pkg::IC_OP && ifun_ff > y86isc_pkg::ALU_XOR);

   always_comb begin
      case (icode_ff)
         y86isc_pkg::IC_RMMOV, y86isc_pkg::IC_MRMOV: ea = vb_ff + imm_ff;
         y86isc_pkg::IC_CALL, y86isc_pkg::IC_PUSH:   ea = vsp_ff - 64'd8;
         default:                                   ea = vsp_ff;
      endcase
   end

   always_comb begin
      alu_o = 1'b0;
      case (ifun_ff)
         y86isc_pkg::ALU_ADD: begin
            alu_v = va_ff + vb_ff;
            alu_o = ((va_ff[63] ^ alu_v[63]) & (vb_ff[63] ^ alu_v[63]));
         end
         y86isc_pkg::ALU_SUB: begin
            alu_v = vb_ff - va_ff;
            alu_o = ((vb_ff[63] ^ va_ff[63]) & (vb_ff[63] ^ alu_v[63]));
         end
         y86isc_pkg::ALU_AND: alu_v = va_ff & vb_ff;
         default:             alu_v = va_ff ^ vb_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      pc_in        = pc_ff;
      p_in         = p_ff;
      np_in        = np_ff;
      flags_in     = flags_ff;
      icode_in     = icode_ff;
      ifun_in      = ifun_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      imm_in       = imm_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      vsp_in       = vsp_ff;
      addr_in      = addr_ff;
      data_in      = data_ff;
      status_in    = status_ff;
      rv_in        = rv_ff;
      wr1_in       = wr1_ff;
      wr2_in       = wr2_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = 8'd0;
      mem_re       = 1'b0;
      mem_ra       = '0;
      rf_wr        = '0;
      rf_ra        = y86isc_pkg::NO_REG;

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               status_in = y86isc_pkg::ST_AOK;
               rv_in     = 64'd0;
               p_in      = pc_ff;
               wr1_in    = '0;
               wr2_in    = '0;
               ra_in     = y86isc_pkg::NO_REG;
               rb_in     = y86isc_pkg::NO_REG;
               case (req_data.action)
                  y86isc_pkg::ACT_LOAD: begin
                     if (64'(req_data.address) < MEM_LIMIT) begin
                        mem_we = 1'b1;
                        mem_wa = AW'(req_data.address);
                        mem_wd = req_data.load_byte;
                     end else begin
                        status_in = y86isc_pkg::ST_ADR;
                     end
                     state_in = S_RESP;
                  end
                  y86isc_pkg::ACT_READ_MEM: begin
                     if (64'(req_data.address) < MEM_LIMIT) begin
                        mem_re   = 1'b1;
                        mem_ra   = AW'(req_data.address);
                        state_in = S_MRDW;
                     end else begin
                        status_in = y86isc_pkg::ST_ADR;
                        state_in  = S_RESP;
                     end
                  end
                  y86isc_pkg::ACT_READ_REG: begin
                     if (req_data.address < 13'(y86isc_pkg::REG_COUNT)) begin
                        rf_ra = req_data.address[3:0];
                     end
                     state_in = S_RRDW;
                  end
                  default: state_in = S_F0;
               endcase
            end
         end
         S_MRDW: begin
            rv_in    = {56'd0, mem_rd_ff};
            state_in = S_RESP;
         end
         S_RRDW: begin
            rv_in    = rf_rdata;
            state_in = S_RESP;
         end
         S_F0: begin
            if (pc_ff < MEM_LIMIT) begin
               mem_re   = 1'b1;
               mem_ra   = AW'(pc_ff);
               state_in = S_F0W;
            end else begin
               status_in = y86isc_pkg::ST_ADR;
               state_in  = S_RESP;
            end
         end
         S_F0W: begin
            icode_in = mem_rd_ff[7:4];
            ifun_in  = mem_rd_ff[3:0];
            np_in    = pc_ff + 64'd1;
            cnt_in   = 4'd0;
            addr_in  = pc_ff + 64'd1;
            if (mem_rd_ff[7:4] > y86isc_pkg::IC_POP) begin
               status_in = y86isc_pkg::ST_INS;
               state_in  = S_RESP;
            end else if (y86isc_pkg::need_reg(mem_rd_ff[7:4])) begin
               if (pc_ff + 64'd1 < MEM_LIMIT) begin
                  mem_re   = 1'b1;
                  mem_ra   = AW'(pc_ff + 64'd1);
                  state_in = S_F1W;
               end else begin
                  status_in = y86isc_pkg::ST_ADR;
                  state_in  = S_RESP;
               end
            end else if (y86isc_pkg::need_imm(mem_rd_ff[7:4])) begin
               if (pc_ff + 64'd1 <= SPAN8_MAX) begin
                  state_in = S_IMM;
               end else begin
                  status_in = y86isc_pkg::ST_ADR;
                  state_in  = S_RESP;
               end
            end else begin
               state_in = S_DEC;
            end
         end
         S_F1W: begin
            ra_in   = mem_rd_ff[7:4];
            rb_in   = mem_rd_ff[3:0];
            np_in   = np_ff + 64'd1;
            cnt_in  = 4'd0;
            addr_in = np_ff + 64'd1;
            if (y86isc_pkg::need_imm(icode_ff)) begin
               if (np_ff + 64'd1 <= SPAN8_MAX) begin
                  state_in = S_IMM;
               end else begin
                  status_in = y86isc_pkg::ST_ADR;
                  state_in  = S_RESP;
               end
            end else begin
               state_in = S_DEC;
            end
         end
         S_IMM, S_DRD: begin
            if (cnt_ff < 4'd8) begin
               mem_re = 1'b1;
               mem_ra = AW'(addr_ff) + AW'(cnt_ff);
            end
            if (cnt_ff != 4'd0) begin
               data_in = rd8_val;
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd8) begin
               if (state_ff == S_IMM) begin
                  imm_in   = rd8_val;
                  np_in    = np_ff + 64'd8;
                  state_in = S_DEC;
               end else begin
                  case (icode_ff)
                     y86isc_pkg::IC_MRMOV: wr1_in.value = rd8_val;
                     y86isc_pkg::IC_RET:   p_in = rd8_val;
                     default:              wr2_in = {1'b1, ra_ff, rd8_val};
                  endcase
                  state_in = S_RWR1;
               end
            end
         end
         S_DEC: begin
            cnt_in = 4'd0;
            if (bad_fn) begin
               status_in = y86isc_pkg::ST_INS;
               state_in  = S_RESP;
            end else begin
               state_in = S_REGRD;
            end
         end
         S_REGRD: begin
            case (cnt_ff)
               4'd0:    rf_ra = ra_ff;
               4'd1:    rf_ra = rb_ff;
               4'd2:    rf_ra = y86isc_pkg::RSP_ID;
               default: rf_ra = y86isc_pkg::NO_REG;
            endcase
            case (cnt_ff)
               4'd1:    va_in  = rf_rdata;
               4'd2:    vb_in  = rf_rdata;
               4'd3:    vsp_in = rf_rdata;
               default: va_in  = va_ff;
            endcase
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd3) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            p_in     = np_ff;
            cnt_in   = 4'd0;
            addr_in  = ea;
            state_in = S_RWR1;
            case (icode_ff)
               y86isc_pkg::IC_HALT: begin
                  status_in = y86isc_pkg::ST_HLT;
                  p_in      = pc_ff;
                  state_in  = S_RESP;
               end
               y86isc_pkg::IC_NOP: state_in = S_RESP;
               y86isc_pkg::IC_CMOV:  wr1_in = {cond, rb_ff, va_ff};
               y86isc_pkg::IC_IRMOV: wr1_in = {1'b1, rb_ff, imm_ff};
               y86isc_pkg::IC_OP: begin
                  wr1_in   = {1'b1, rb_ff, alu_v};
                  flags_in = {(alu_v == 64'd0), alu_v[63], alu_o};
               end
               y86isc_pkg::IC_JXX: begin
                  if (cond) begin
                     p_in = imm_ff;
                  end
                  state_in = S_RESP;
               end
               default: begin
                  if (ea <= SPAN8_MAX) begin
                     case (icode_ff)
                        y86isc_pkg::IC_RMMOV: begin
                           data_in  = va_ff;
                           state_in = S_DWR;
                        end
                        y86isc_pkg::IC_MRMOV: begin
                           wr1_in   = {1'b1, ra_ff, 64'd0};
                           state_in = S_DRD;
                        end
                        y86isc_pkg::IC_CALL: begin
                           data_in  = np_ff;
                           wr1_in   = {1'b1, y86isc_pkg::RSP_ID, ea};
                           p_in     = imm_ff;
                           state_in = S_DWR;
                        end
                        y86isc_pkg::IC_PUSH: begin
                           data_in  = va_ff;
                           wr1_in   = {1'b1, y86isc_pkg::RSP_ID, ea};
                           state_in = S_DWR;
                        end
                        default: begin
                           wr1_in   = {1'b1, y86isc_pkg::RSP_ID, vsp_ff + 64'd8};
                           state_in = S_DRD;
                        end
                     endcase
                  end else begin
                     status_in = y86isc_pkg::ST_ADR;
                     p_in      = pc_ff;
                     state_in  = S_RESP;
                  end
               end
            endcase
         end
         S_DWR: begin
            mem_we  = 1'b1;
            mem_wa  = AW'(addr_ff) + AW'(cnt_ff);
            mem_wd  = data_ff[7:0];
            data_in = {8'd0, data_ff[63:8]};
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == 4'd7) begin
               state_in = S_RWR1;
            end
         end
         S_RWR1: begin
            rf_wr    = wr1_ff;
            state_in = wr2_ff.en ? S_RWR2 : S_RESP;
         end
         S_RWR2: begin
            rf_wr    = wr2_ff;
            state_in = S_RESP;
         end
         default: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = {status_ff, p_ff, flags_ff, rv_ff};
               rsp_valid_in = 1'b1;
               pc_in        = p_ff;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= 64'd0;
         flags_ff     <= y86isc_pkg::FLAGS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pc_ff        <= pc_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      p_ff      <= p_in;
      np_ff     <= np_in;
      icode_ff  <= icode_in;
      ifun_ff   <= ifun_in;
      ra_ff     <= ra_in;
      rb_ff     <= rb_in;
      imm_ff    <= imm_in;
      va_ff     <= va_in;
      vb_ff     <= vb_in;
      vsp_ff    <= vsp_in;
      addr_ff   <= addr_in;
      data_ff   <= data_in;
      status_ff <= status_in;
      rv_ff     <= rv_in;
      wr1_ff    <= wr1_in;
      wr2_ff    <= wr2_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/core/y86isc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module y86isc_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire y86isc_pkg::req_type req_data,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire y86isc_pkg::rsp_type rsp_data
);

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // one transaction at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a transaction in progress");

   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != y86isc_pkg::ST_AOK |-> rsp_data.read_value == 64'd0)
      else $error("error result carries read data");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind y86_instruction_step_core_top y86isc_checker u_checker (.*);

`default_nettype wire
